### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers clocked on clk, reset on arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked also during reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/pbrq_pkg.sv
// ----------------------------------------------------------------------------
// pbrq_pkg
// shared types, codes and defaults of the priority bitmap ready queue
// ----------------------------------------------------------------------------
`default_nettype none

package pbrq_pkg;

	localparam int unsigned DEF_NUM_PRIORITIES = 32;
	localparam int unsigned DEF_LEVEL_DEPTH    = 16;
	localparam int unsigned DEF_ID_BITS        = 8;

	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_TAKE    = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic       command;
		logic [7:0] thread_id;
		logic [4:0] priority_req;
	} pbrq_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] next_thread;
		logic [4:0] next_priority;
	} pbrq_rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_CTRL,
		S_POP
	} pbrq_state_t;

	typedef struct packed {
		logic       capture;
		logic       lookup;
		logic       store_rd;
		logic       commit_enq;
		logic       commit_pop;
		logic       report;
		logic [1:0] report_status;
	} pbrq_cmd_t;

	typedef struct packed {
		logic is_take;
		logic level_hit;
		logic fill_full;
		logic fill_empty;
	} pbrq_stat_t;

endpackage

`default_nettype wire

### sv/pbrq_ctrl.sv
// ----------------------------------------------------------------------------
// pbrq_ctrl
// sequencer: lookup, level control read, store read, commit and report
// ----------------------------------------------------------------------------
`default_nettype none

module pbrq_ctrl
	import pbrq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire pbrq_stat_t stat,
	output pbrq_cmd_t       cmd,
	output logic            busy
);

	pbrq_state_t state_q;
	pbrq_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				state_d = stat.level_hit ? S_CTRL : S_IDLE;
			end
			S_CTRL: begin
				state_d = (stat.is_take && !stat.fill_empty) ? S_POP : S_IDLE;
			end
			S_POP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.capture = start;
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (!stat.level_hit) begin
					cmd.report        = 1'b1;
					cmd.report_status = stat.is_take ? STATUS_EMPTY : STATUS_OVERFLOW;
				end
			end
			S_CTRL: begin
				if (stat.is_take) begin
					if (stat.fill_empty) begin
						cmd.report        = 1'b1;
						cmd.report_status = STATUS_EMPTY;
					end else begin
						cmd.store_rd = 1'b1;
					end
				end else if (stat.fill_full) begin
					cmd.report        = 1'b1;
					cmd.report_status = STATUS_OVERFLOW;
				end else begin
					cmd.commit_enq    = 1'b1;
					cmd.report        = 1'b1;
					cmd.report_status = STATUS_OK;
				end
			end
			S_POP: begin
				cmd.commit_pop    = 1'b1;
				cmd.report        = 1'b1;
				cmd.report_status = STATUS_OK;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/pbrq_datapath.sv
// ----------------------------------------------------------------------------
// pbrq_datapath
// ready bitmap, per-level head/tail/fill memory, id store and result register
// ----------------------------------------------------------------------------
`default_nettype none

module pbrq_datapath
	import pbrq_pkg::*;
#(
	parameter int unsigned NUM_PRIORITIES = DEF_NUM_PRIORITIES,
	parameter int unsigned LEVEL_DEPTH    = DEF_LEVEL_DEPTH,
	parameter int unsigned ID_BITS        = DEF_ID_BITS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pbrq_req_t request,
	input  wire pbrq_cmd_t cmd,
	output pbrq_stat_t     stat,
	output logic           done,
	output pbrq_rsp_t      result
);

	localparam int unsigned LVL_W       = $clog2(NUM_PRIORITIES);
	localparam int unsigned IDX_W       = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int unsigned FILL_W      = $clog2(LEVEL_DEPTH + 1);
	localparam int unsigned STORE_DEPTH = NUM_PRIORITIES * LEVEL_DEPTH;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

	typedef struct packed {
		logic [IDX_W-1:0]  head;
		logic [IDX_W-1:0]  tail;
		logic [FILL_W-1:0] fill;
	} level_ctrl_t;

	pbrq_req_t                 req_q;
	logic [LVL_W-1:0]          level_q;
	logic [NUM_PRIORITIES-1:0] bitmap_q;
	logic [NUM_PRIORITIES-1:0] ctrl_vld_q;
	level_ctrl_t               ctrl_mem [NUM_PRIORITIES];
	level_ctrl_t               ctrl_rd_q;
	logic                      ctrl_rd_vld_q;
	logic [ID_BITS-1:0]        store_mem [STORE_DEPTH];
	logic [ID_BITS-1:0]        store_rd_q;
	logic                      done_q;
	pbrq_rsp_t                 result_q;

	logic [LVL_W-1:0]  ffs_level;
	logic              ffs_found;
	logic [31:0]       prio_wide;
	logic [LVL_W-1:0]  prio_level;
	logic              prio_in_range;
	logic [LVL_W-1:0]  lookup_level;
	level_ctrl_t       ctrl_cur;
	level_ctrl_t       ctrl_wd;
	logic [IDX_W-1:0]  head_next;
	logic [IDX_W-1:0]  tail_next;
	logic [ADDR_W-1:0] level_base;
	logic [ADDR_W-1:0] store_wr_addr;
	logic [ADDR_W-1:0] store_rd_addr;
	logic [31:0]       in_id_wide;
	logic [31:0]       out_id_wide;
	logic [31:0]       out_level_wide;

	// lowest set level of the ready bitmap
	always_comb begin
		ffs_level = '0;
		ffs_found = 1'b0;
		for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
			if (bitmap_q[i]) begin
				ffs_level = LVL_W'(i);
				ffs_found = 1'b1;
			end
		end
	end

	assign prio_wide     = 32'(req_q.priority_req);
	assign prio_level    = prio_wide[LVL_W-1:0];
	assign prio_in_range = (prio_wide < 32'(NUM_PRIORITIES));
	assign lookup_level  = (req_q.command == CMD_TAKE) ? ffs_level : prio_level;

	// entries never written read as an empty level
	assign ctrl_cur  = ctrl_rd_vld_q ? ctrl_rd_q : '0;
	assign head_next = (ctrl_cur.head == IDX_W'(LEVEL_DEPTH - 1)) ? '0
		: ctrl_cur.head + IDX_W'(1);
	assign tail_next = (ctrl_cur.tail == IDX_W'(LEVEL_DEPTH - 1)) ? '0
		: ctrl_cur.tail + IDX_W'(1);

	always_comb begin
		ctrl_wd = ctrl_cur;
		if (cmd.commit_enq) begin
			ctrl_wd.tail = tail_next;
			ctrl_wd.fill = ctrl_cur.fill + FILL_W'(1);
		end else begin
			ctrl_wd.head = head_next;
			ctrl_wd.fill = ctrl_cur.fill - FILL_W'(1);
		end
	end

	assign level_base    = ADDR_W'(level_q) * ADDR_W'(LEVEL_DEPTH);
	assign store_wr_addr = level_base + ADDR_W'(ctrl_cur.tail);
	assign store_rd_addr = level_base + ADDR_W'(ctrl_cur.head);

	assign in_id_wide     = 32'(req_q.thread_id);
	assign out_id_wide    = 32'(store_rd_q);
	assign out_level_wide = 32'(level_q);

	assign stat.is_take    = (req_q.command == CMD_TAKE);
	assign stat.level_hit  = (req_q.command == CMD_TAKE) ? ffs_found : prio_in_range;
	assign stat.fill_full  = (ctrl_cur.fill >= FILL_W'(LEVEL_DEPTH));
	assign stat.fill_empty = (ctrl_cur.fill == '0);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_q   <= '0;
			ctrl_vld_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.report;
			if (cmd.commit_enq) begin
				bitmap_q[level_q]   <= 1'b1;
				ctrl_vld_q[level_q] <= 1'b1;
			end
			if (cmd.commit_pop && ctrl_cur.fill == FILL_W'(1)) begin
				bitmap_q[level_q] <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= request;
		end
		if (cmd.lookup) begin
			level_q       <= lookup_level;
			ctrl_rd_q     <= ctrl_mem[lookup_level];
			ctrl_rd_vld_q <= ctrl_vld_q[lookup_level];
		end
		if (cmd.report) begin
			result_q.status <= cmd.report_status;
			if (cmd.commit_pop) begin
				result_q.next_thread   <= out_id_wide[7:0];
				result_q.next_priority <= out_level_wide[4:0];
			end else begin
				result_q.next_thread   <= '0;
				result_q.next_priority <= '0;
			end
		end
	end

	// level control memory
	always_ff @(posedge clk) begin
		if (cmd.commit_enq || cmd.commit_pop) begin
			ctrl_mem[level_q] <= ctrl_wd;
		end
	end

	// thread id store
	always_ff @(posedge clk) begin
		if (cmd.commit_enq) begin
			store_mem[store_wr_addr] <= in_id_wide[ID_BITS-1:0];
		end
		if (cmd.store_rd) begin
			store_rd_q <= store_mem[store_rd_addr];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

### sv/priority_bitmap_ready_queue_top.sv
// ----------------------------------------------------------------------------
// priority_bitmap_ready_queue_top
// multilevel ready queue, one fifo per priority level and a ready bitmap
//
// channel   ports                    transfer
// input     start, busy, request     edge with start high and busy low
// output    done, result             edge ending the one-cycle done strobe
//
// enqueue: lookup, level control read and commit, then done; only lookup
// if the level is out of range. take: lookup, level control read with the
// id store read, pop, then done; only lookup if no level is ready
// reset clears the ready bitmap and the level control valid bits at once
// busy stays high from transfer until done; the receiver cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

module priority_bitmap_ready_queue_top
	import pbrq_pkg::*;
#(
	parameter int unsigned NUM_PRIORITIES = DEF_NUM_PRIORITIES,
	parameter int unsigned LEVEL_DEPTH    = DEF_LEVEL_DEPTH,
	parameter int unsigned ID_BITS        = DEF_ID_BITS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire pbrq_req_t request,
	output logic           busy,
	output logic           done,
	output pbrq_rsp_t      result
);

	pbrq_cmd_t  cmd;
	pbrq_stat_t stat;

	pbrq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	pbrq_datapath #(
		.NUM_PRIORITIES (NUM_PRIORITIES),
		.LEVEL_DEPTH    (LEVEL_DEPTH),
		.ID_BITS        (ID_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

endmodule

`default_nettype wire

### sv/pbrq_checker.sv
// ----------------------------------------------------------------------------
// pbrq_checker
// port-level checks of the ready queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pbrq_checker
	import pbrq_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire logic      done,
	input wire pbrq_rsp_t result
);

	`ASSERT_CLK(a_busy_after_transfer, (start && !busy) |=> busy, "busy low after transfer")
	`ASSERT_CLK(a_no_early_done, (start && !busy) |=> !done, "done one cycle after transfer")
	`ASSERT_CLK(a_done_single, done |=> !done, "done held two cycles")
	`ASSERT_CLK(a_status_code,
		done |-> (result.status == STATUS_OK || result.status == STATUS_EMPTY ||
		result.status == STATUS_OVERFLOW), "undefined status code")
	`ASSERT_CLK_ALWAYS(a_fail_zero,
		(done && result.status != STATUS_OK) |->
		(result.next_thread == '0 && result.next_priority == '0),
		"nonzero fields on failed item")

endmodule

bind priority_bitmap_ready_queue_top pbrq_checker u_pbrq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire
